>>> design/quoted_field_splitter_macros.svh
`ifndef QUOTED_FIELD_SPLITTER_MACROS_SVH
`define QUOTED_FIELD_SPLITTER_MACROS_SVH

// checked only while out of reset
`define QFS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("quoted_field_splitter assertion failed");

// checked at every edge, reset included
`define QFS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("quoted_field_splitter assertion failed");

`endif

>>> design/qfs_pkg.sv
`default_nettype none

package qfs_pkg;

   localparam logic [7:0]  QUOTE_BYTE     = 8'h22;
   localparam logic [63:0] SEP_MASK0_INIT = 64'h0000_1000_0000_0000;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_END  = 1'b1;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_EOF  = 1'b1;

   localparam logic [2:0] CSR_SEP_MASK_0 = 3'd0;
   localparam logic [2:0] CSR_SEP_MASK_1 = 3'd1;
   localparam logic [2:0] CSR_SEP_MASK_2 = 3'd2;
   localparam logic [2:0] CSR_SEP_MASK_3 = 3'd3;

   typedef struct packed {
      logic       op;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] out_byte;
      logic       end_of_record;
      logic       unterminated_quote;
      logic       last_of_run;
   } rsp_type;

endpackage

`default_nettype wire

>>> design/quoted_field_splitter.sv
// Results of an accepted word are written into the result queue and offered from its head.
// Throughput: one word per cycle while input ready is high; a word yielding two results
// leaves them one at a time, limited by the single result port, with a four-entry result
// queue absorbing bursts. Input ready is high while the queue has room for two results.
// Reset (synchronous, active high): separator set to comma only, parser at field start,
// result queue empty.
`default_nettype none

module quoted_field_splitter
   import qfs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   typedef enum logic [1:0] {
      MODE_START  = 2'd0,
      MODE_PLAIN  = 2'd1,
      MODE_QUOTED = 2'd2,
      MODE_HELD   = 2'd3
   } mode_type;

   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);
   localparam int QCW    = $clog2(QDEPTH + 1);

   mode_type          mode_ff, mode_in;
   logic [63:0]       mask_ff [4];
   rsp_type           q_ff [QDEPTH];
   logic [QAW-1:0]    head_ff, tail_ff;
   logic [QCW-1:0]    count_ff, count_in;

   rsp_type           res0, res1;
   logic [1:0]        n_res;
   logic              is_sep, is_quote;
   logic              push, pop;
   logic [7:0]        b;

   assign b         = req_data.in_byte;
   assign is_sep    = mask_ff[b[7:6]][b[5:0]];
   assign is_quote  = (b == QUOTE_BYTE);
   assign req_ready = (count_ff <= QCW'(QDEPTH - 2));
   assign push      = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = q_ff[head_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      res0    = '0;
      res1    = '0;
      n_res   = 2'd0;
      mode_in = mode_ff;
      if (req_data.op == OP_END) begin
         res0.kind               = KIND_EOF;
         res0.end_of_record      = 1'b1;
         res0.unterminated_quote = (mode_ff == MODE_QUOTED);
         n_res                   = 2'd1;
         mode_in                 = MODE_START;
      end else begin
         unique case (mode_ff)
            MODE_START: begin
               if (is_quote) begin
                  mode_in = MODE_QUOTED;
               end else if (is_sep) begin
                  res0.kind = KIND_EOF;
                  n_res     = 2'd1;
               end else begin
                  res0.kind     = KIND_DATA;
                  res0.out_byte = b;
                  n_res         = 2'd1;
                  mode_in       = MODE_PLAIN;
               end
            end
            MODE_PLAIN: begin
               n_res = 2'd1;
               if (is_sep) begin
                  res0.kind = KIND_EOF;
                  mode_in   = MODE_START;
               end else begin
                  res0.kind     = KIND_DATA;
                  res0.out_byte = b;
               end
            end
            MODE_QUOTED: begin
               if (is_quote) begin
                  mode_in = MODE_HELD;
               end else begin
                  res0.kind     = KIND_DATA;
                  res0.out_byte = b;
                  n_res         = 2'd1;
               end
            end
            MODE_HELD: begin
               if (is_sep) begin
                  res0.kind = KIND_EOF;
                  n_res     = 2'd1;
                  mode_in   = MODE_START;
               end else if (is_quote) begin
                  res0.kind     = KIND_DATA;
                  res0.out_byte = QUOTE_BYTE;
                  n_res         = 2'd1;
               end else begin
                  res0.kind     = KIND_DATA;
                  res0.out_byte = QUOTE_BYTE;
                  res1.kind     = KIND_DATA;
                  res1.out_byte = b;
                  n_res         = 2'd2;
                  mode_in       = MODE_QUOTED;
               end
            end
            default: begin
               mode_in = MODE_START;
            end
         endcase
      end
      res0.last_of_run = (n_res == 2'd1);
      res1.last_of_run = (n_res == 2'd2);
   end

   always_comb begin
      count_in = count_ff;
      if (push) begin
         count_in = count_in + QCW'(n_res);
      end
      if (pop) begin
         count_in = count_in - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_START;
         mask_ff[0] <= SEP_MASK0_INIT;
         mask_ff[1] <= '0;
         mask_ff[2] <= '0;
         mask_ff[3] <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_SEP_MASK_0: mask_ff[0] <= csr_wdata;
               CSR_SEP_MASK_1: mask_ff[1] <= csr_wdata;
               CSR_SEP_MASK_2: mask_ff[2] <= csr_wdata;
               CSR_SEP_MASK_3: mask_ff[3] <= csr_wdata;
               default: ;
            endcase
         end
         if (push) begin
            mode_ff <= mode_in;
            if (n_res != 2'd0) begin
               q_ff[tail_ff] <= res0;
            end
            if (n_res == 2'd2) begin
               q_ff[tail_ff + QAW'(1)] <= res1;
            end
            tail_ff <= tail_ff + QAW'(n_res);
         end
         if (pop) begin
            head_ff <= head_ff + QAW'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> design/qfs_checker.sv
`default_nettype none
`include "quoted_field_splitter_macros.svh"

module qfs_checker
   import qfs_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire rsp_type     rsp_data
);

   logic rsp_stall, rsp_eor, rsp_unterm, rsp_eof, eor_closes;

   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign rsp_eor    = rsp_valid && rsp_data.end_of_record;
   assign rsp_unterm = rsp_valid && rsp_data.unterminated_quote;
   assign rsp_eof    = rsp_valid && (rsp_data.kind == KIND_EOF);
   assign eor_closes = (rsp_data.kind == KIND_EOF) && rsp_data.last_of_run;

   `QFS_ASSERT_ALWAYS(a_empty_after_reset, clock, reset |=> !rsp_valid)
   `QFS_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_data))
   `QFS_ASSERT(a_eor_closes, clock, reset, rsp_eor |-> eor_closes)
   `QFS_ASSERT(a_unterm_at_eor, clock, reset, rsp_unterm |-> rsp_data.end_of_record)
   `QFS_ASSERT(a_eof_zero_byte, clock, reset, rsp_eof |-> rsp_data.out_byte == 8'h00)

endmodule

bind quoted_field_splitter qfs_checker u_qfs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

import qfs_pkg::*;

typedef enum logic [1:0] {
   AT_FIELD_START,
   IN_PLAIN,
   IN_QUOTED,
   QUOTE_HELD
} parse_mode_type;

class field_tracker_type;
   logic [63:0]    sep_mask [4];
   parse_mode_type mode;
   rsp_type        pending_results [$];
   int             error_count;

   function new();
      sep_mask[0] = SEP_MASK0_INIT;
      sep_mask[1] = '0;
      sep_mask[2] = '0;
      sep_mask[3] = '0;
      mode = AT_FIELD_START;
      error_count = 0;
   endfunction

   function void set_mask(logic [2:0] idx, logic [63:0] value);
      if (idx <= CSR_SEP_MASK_3) sep_mask[idx[1:0]] = value;
   endfunction

   function bit is_separator(logic [7:0] value);
      return sep_mask[value[7:6]][value[5:0]];
   endfunction

   function rsp_type content(logic [7:0] value);
      rsp_type r;
      r = '0;
      r.kind = KIND_DATA;
      r.out_byte = value;
      return r;
   endfunction

   function rsp_type field_end(logic eor, logic unterm);
      rsp_type r;
      r = '0;
      r.kind = KIND_EOF;
      r.end_of_record = eor;
      r.unterminated_quote = unterm;
      return r;
   endfunction

   function void accept_word(req_type w);
      rsp_type produced [$];
      if (w.op == OP_END) begin
         produced = {produced, field_end(1'b1, mode == IN_QUOTED)};
         mode = AT_FIELD_START;
      end else begin
         case (mode)
            AT_FIELD_START: begin
               if (w.in_byte == QUOTE_BYTE) begin
                  mode = IN_QUOTED;
               end else if (is_separator(w.in_byte)) begin
                  produced = {produced, field_end(1'b0, 1'b0)};
               end else begin
                  produced = {produced, content(w.in_byte)};
                  mode = IN_PLAIN;
               end
            end
            IN_PLAIN: begin
               if (is_separator(w.in_byte)) begin
                  produced = {produced, field_end(1'b0, 1'b0)};
                  mode = AT_FIELD_START;
               end else begin
                  produced = {produced, content(w.in_byte)};
               end
            end
            IN_QUOTED: begin
               if (w.in_byte == QUOTE_BYTE) mode = QUOTE_HELD;
               else produced = {produced, content(w.in_byte)};
            end
            default: begin
               if (is_separator(w.in_byte)) begin
                  produced = {produced, field_end(1'b0, 1'b0)};
                  mode = AT_FIELD_START;
               end else if (w.in_byte == QUOTE_BYTE) begin
                  produced = {produced, content(QUOTE_BYTE)};
               end else begin
                  produced = {produced, content(QUOTE_BYTE)};
                  produced = {produced, content(w.in_byte)};
                  mode = IN_QUOTED;
               end
            end
         endcase
      end
      if (produced.size() > 0) produced[produced.size() - 1].last_of_run = 1'b1;
      foreach (produced[i]) pending_results = {pending_results, produced[i]};
   endfunction

   function void check_result(rsp_type got);
      rsp_type want;
      if (pending_results.size() == 0) begin
         $error("unexpected result %h", got);
         error_count++;
         return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind) begin
         $error("kind: expected %0d, got %0d", want.kind, got.kind);
         error_count++;
      end
      if (got.out_byte !== want.out_byte) begin
         $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
         error_count++;
      end
      if (got.end_of_record !== want.end_of_record) begin
         $error("end_of_record: expected %0d, got %0d", want.end_of_record,
                got.end_of_record);
         error_count++;
      end
      if (got.unterminated_quote !== want.unterminated_quote) begin
         $error("unterminated_quote: expected %0d, got %0d", want.unterminated_quote,
                got.unterminated_quote);
         error_count++;
      end
      if (got.last_of_run !== want.last_of_run) begin
         $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
         error_count++;
      end
   endfunction
endclass

module tb_top;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_STALL  = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = CSR_SEP_MASK_0;
   logic [63:0] csr_wdata = '0;

   field_tracker_type tracker = new();

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int words_sent = 0;
   int long_stall_requests = 0;
   int stalls_done = 0;
   int stall_left = 0;
   int cycle_count = 0;

   quoted_field_splitter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_result(rsp_data);
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stalls_done != long_stall_requests) begin
         stalls_done <= long_stall_requests;
         stall_left <= LONG_STALL;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_word(req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      tracker.accept_word(w);
      words_sent++;
   endtask

   task automatic send_byte(logic [7:0] value);
      send_word('{op: OP_BYTE, in_byte: value});
   endtask

   task automatic end_record(logic [7:0] ignored);
      send_word('{op: OP_END, in_byte: ignored});
   endtask

   function automatic logic [7:0] pick_separator(output bit found);
      logic [7:0] b;
      found = 1'b0;
      for (int i = 0; i < 64; i++) begin
         b = 8'($urandom_range(255));
         if (tracker.is_separator(b)) begin
            found = 1'b1;
            return b;
         end
      end
      for (int i = 0; i < 256; i++) begin
         if (tracker.is_separator(i[7:0])) begin
            found = 1'b1;
            return i[7:0];
         end
      end
      return 8'h00;
   endfunction

   function automatic logic [7:0] pick_plain(bit first, output bit found);
      logic [7:0] b;
      found = 1'b0;
      for (int i = 0; i < 64; i++) begin
         b = 8'($urandom_range(255));
         if (!tracker.is_separator(b) && !(first && b == QUOTE_BYTE)) begin
            found = 1'b1;
            return b;
         end
      end
      return 8'h00;
   endfunction

   task automatic send_record();
      int         nfields;
      int         style;
      int         len;
      bit         found;
      logic [7:0] b;
      nfields = $urandom_range(1, 4);
      for (int f = 0; f < nfields; f++) begin
         style = $urandom_range(0, 3);
         if (style == 1) begin
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++) begin
               b = pick_plain(i == 0, found);
               if (found) send_byte(b);
            end
         end else if (style >= 2) begin
            send_byte(QUOTE_BYTE);
            len = $urandom_range(0, 6);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(5) == 0) begin
                  send_byte(QUOTE_BYTE);
                  send_byte(QUOTE_BYTE);
               end else begin
                  b = 8'($urandom_range(255));
                  if (b != QUOTE_BYTE) send_byte(b);
               end
            end
            if (style == 2 || f < nfields - 1) send_byte(QUOTE_BYTE);
         end
         if (f < nfields - 1) begin
            b = pick_separator(found);
            if (found) send_byte(b);
         end
      end
      end_record(8'($urandom_range(255)));
   endtask

   task automatic send_noise();
      int     n;
      req_type w;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         w.op = ($urandom_range(4) == 0) ? OP_END : OP_BYTE;
         w.in_byte = 8'($urandom_range(255));
         send_word(w);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mask(logic [2:0] idx, logic [63:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.set_mask(idx, value);
   endtask

   task automatic write_masks(logic [63:0] m0, logic [63:0] m1, logic [63:0] m2,
                              logic [63:0] m3);
      write_mask(CSR_SEP_MASK_0, m0);
      write_mask(CSR_SEP_MASK_1, m1);
      write_mask(CSR_SEP_MASK_2, m2);
      write_mask(CSR_SEP_MASK_3, m3);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(int target, int sidle, int ridle, bit long_stall);
      int start;
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      start = words_sent;
      if (long_stall) long_stall_requests++;
      while (words_sent - start < target) begin
         if ($urandom_range(99) < 20) send_noise();
         else send_record();
      end
      drain();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      end_record(8'h00);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h2C);
      send_byte(8'h2C);
      send_byte(QUOTE_BYTE);
      send_byte(8'h2C);
      send_byte(QUOTE_BYTE);
      send_byte(QUOTE_BYTE);
      send_byte(8'h7A);
      send_byte(QUOTE_BYTE);
      send_byte(8'h2C);
      send_byte(QUOTE_BYTE);
      send_byte(QUOTE_BYTE);
      end_record(8'h00);
      send_byte(QUOTE_BYTE);
      send_byte(8'h80);
      end_record(8'hFF);
      send_byte(8'h61);
      send_byte(QUOTE_BYTE);
      end_record(8'h55);
      drain();

      write_masks(SEP_MASK0_INIT | 64'h0800_0000_0000_0200, 64'h1000_0000_0000_0000,
                  64'h0, {$urandom, $urandom});
      run_phase(140, 20, 48, 1'b0);
      write_masks('0, '0, '0, '0);
      run_phase(140, 20, 48, 1'b0);
      write_masks('1, '1, '1, '1);
      run_phase(140, 48, 20, 1'b0);
      write_masks({$urandom, $urandom} & {$urandom, $urandom},
                  {$urandom, $urandom} & {$urandom, $urandom},
                  {$urandom, $urandom} & {$urandom, $urandom},
                  {$urandom, $urandom} & {$urandom, $urandom});
      run_phase(140, 48, 20, 1'b0);
      write_masks(SEP_MASK0_INIT | 64'h0000_0005_0000_0000, 64'h0,
                  64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000);
      run_phase(140, 0, 0, 1'b1);
      write_masks({$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
      run_phase(140, 0, 0, 1'b0);

      repeat (10) @(posedge clock);
      if (tracker.error_count == 0 && tracker.pending_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

>>> filelist.f
+incdir+design
design/qfs_pkg.sv
design/quoted_field_splitter.sv
design/qfs_checker.sv
tb/sv/tb_top.sv
